/* rtl/core/doubly_linked_list_cursor_assert.svh */
// Assertion macros used by the list cursor top level.
`ifndef DOUBLY_LINKED_LIST_CURSOR_ASSERT_SVH
`define DOUBLY_LINKED_LIST_CURSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list cursor same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list cursor next-cycle check failed");

`endif

/* rtl/core/dllc_pkg.sv */
// Types and codes shared by the list cursor modules.
package dllc_pkg;

	typedef logic [2:0] opcode_t;
	typedef logic [1:0] status_t;
	typedef logic [31:0] data_word_t;
	typedef logic [4:0] count_word_t;

	localparam opcode_t OP_APPEND = 3'd0;
	localparam opcode_t OP_FIRST  = 3'd1;
	localparam opcode_t OP_NEXT   = 3'd2;
	localparam opcode_t OP_PREV   = 3'd3;
	localparam opcode_t OP_REMOVE = 3'd4;
	localparam opcode_t OP_COUNT  = 3'd5;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_END       = 2'd1;
	localparam status_t ST_FULL      = 2'd2;
	localparam status_t ST_NO_CURSOR = 2'd3;

	typedef struct packed {
		opcode_t    opcode;
		data_word_t data_in;
	} req_word_t;

	typedef struct packed {
		status_t     status;
		data_word_t  data_out;
		count_word_t count_out;
	} rsp_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_LINK,
		S_DATA,
		S_APPEND,
		S_REMOVE
	} state_t;

endpackage

/* rtl/core/dllc_out_reg.sv */
// Output register that holds one response word until the receiver takes it.
module dllc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dllc_pkg::rsp_word_t load_word,
	output logic                free,
	output logic                valid,
	input  logic                stall,
	output dllc_pkg::rsp_word_t word
);
	import dllc_pkg::*;

	logic      valid_q;
	rsp_word_t word_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_word;
		end
	end

endmodule

/* rtl/core/dllc_engine.sv */
// List sequencer with the link and element memories, the free list and the cursor.
module dllc_engine #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  dllc_pkg::req_word_t req_word,
	input  logic                out_free,
	output logic                load,
	output dllc_pkg::rsp_word_t load_word
);
	import dllc_pkg::*;

	localparam int CW = $clog2(CAPACITY + 2);
	localparam int SW = $clog2(CAPACITY);
	localparam int NW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] HEAD = CW'(CAPACITY);
	localparam logic [CW-1:0] TAIL = CW'(CAPACITY + 1);
	localparam logic [NW-1:0] FULL_COUNT = NW'(CAPACITY);

	function automatic logic is_slot(input logic [CW-1:0] code);
		return code < HEAD;
	endfunction

	state_t                state_q, state_d;
	opcode_t               op_q;
	logic [DATA_WIDTH-1:0] din_q;
	logic [CW-1:0]         first_q, first_d;
	logic [CW-1:0]         last_q, last_d;
	logic [CW-1:0]         cursor_q, cursor_d;
	logic                  cur_ok_q, cur_ok_d;
	logic [NW-1:0]         count_q, count_d;
	logic [CW-1:0]         free_head_q, free_head_d;
	logic [NW-1:0]         fresh_q, fresh_d;
	logic [CW-1:0]         prev_q, prev_d;

	logic [CW-1:0]         next_mem [CAPACITY];
	logic [CW-1:0]         prev_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] data_mem [CAPACITY];

	logic                  rd_en;
	logic [SW-1:0]         rd_addr;
	logic [CW-1:0]         rd_next_q, rd_prev_q;
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  next_we, prev_we, data_we;
	logic [SW-1:0]         next_wa, prev_wa, data_wa;
	logic [CW-1:0]         next_wd, prev_wd;
	logic [DATA_WIDTH-1:0] data_wd;

	logic                  issue_fin, link_fin, fin;
	logic [CW-1:0]         alloc;
	status_t               res_status;
	data_word_t            res_data;

	assign alloc     = is_slot(free_head_q) ? free_head_q : CW'(fresh_q);
	assign req_stall = (state_q != S_IDLE);
	assign load      = fin && out_free;
	assign load_word = '{status: res_status, data_out: res_data,
		count_out: count_word_t'(count_d)};

	always_comb begin
		case (op_q)
			OP_APPEND: issue_fin = (count_q == FULL_COUNT);
			OP_FIRST:  issue_fin = !is_slot(first_q);
			OP_NEXT:   issue_fin = !cur_ok_q || (!is_slot(cursor_q) && !is_slot(first_q));
			OP_PREV:   issue_fin = !cur_ok_q || !is_slot(cursor_q);
			OP_REMOVE: issue_fin = !cur_ok_q || !is_slot(cursor_q);
			default:   issue_fin = 1'b1;
		endcase
		case (op_q)
			OP_NEXT: link_fin = !is_slot(rd_next_q);
			OP_PREV: link_fin = !is_slot(rd_prev_q);
			default: link_fin = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (issue_fin) begin
					if (out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					case (op_q)
						OP_APPEND: state_d = S_APPEND;
						OP_FIRST:  state_d = S_DATA;
						OP_NEXT:   state_d = is_slot(cursor_q) ? S_LINK : S_DATA;
						OP_PREV:   state_d = S_LINK;
						OP_REMOVE: state_d = S_LINK;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_LINK: begin
				if (link_fin) begin
					if (out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = (op_q == OP_REMOVE) ? S_REMOVE : S_DATA;
				end
			end
			S_DATA, S_APPEND, S_REMOVE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		first_d     = first_q;
		last_d      = last_q;
		cursor_d    = cursor_q;
		cur_ok_d    = cur_ok_q;
		count_d     = count_q;
		free_head_d = free_head_q;
		fresh_d     = fresh_q;
		prev_d      = prev_q;
		rd_en       = 1'b0;
		rd_addr     = cursor_q[SW-1:0];
		next_we     = 1'b0;
		next_wa     = alloc[SW-1:0];
		next_wd     = TAIL;
		prev_we     = 1'b0;
		prev_wa     = alloc[SW-1:0];
		prev_wd     = last_q;
		data_we     = 1'b0;
		data_wa     = alloc[SW-1:0];
		data_wd     = din_q;
		fin         = 1'b0;
		res_status  = ST_OK;
		res_data    = '0;
		case (state_q)
			S_ISSUE: begin
				if (issue_fin) begin
					fin = 1'b1;
					case (op_q)
						OP_APPEND: res_status = ST_FULL;
						OP_FIRST:  res_status = ST_END;
						OP_NEXT:   res_status = cur_ok_q ? ST_END : ST_NO_CURSOR;
						OP_PREV:   res_status = cur_ok_q ? ST_END : ST_NO_CURSOR;
						OP_REMOVE: res_status = ST_NO_CURSOR;
						OP_COUNT:  res_status = ST_OK;
						default:   res_status = ST_OK;
					endcase
				end else begin
					case (op_q)
						OP_APPEND: begin
							// Old link of the popped free slot is read before the overwrite.
							rd_en   = is_slot(free_head_q);
							rd_addr = free_head_q[SW-1:0];
							data_we = 1'b1;
							prev_we = 1'b1;
							next_we = 1'b1;
						end
						OP_FIRST: begin
							rd_en    = 1'b1;
							rd_addr  = first_q[SW-1:0];
							cursor_d = first_q;
							cur_ok_d = 1'b1;
						end
						OP_NEXT: begin
							rd_en = 1'b1;
							if (!is_slot(cursor_q)) begin
								rd_addr  = first_q[SW-1:0];
								cursor_d = first_q;
							end
						end
						default: begin
							rd_en = 1'b1;
						end
					endcase
				end
			end
			S_LINK: begin
				case (op_q)
					OP_NEXT: begin
						if (link_fin) begin
							fin        = 1'b1;
							res_status = ST_END;
						end else begin
							rd_en    = 1'b1;
							rd_addr  = rd_next_q[SW-1:0];
							cursor_d = rd_next_q;
						end
					end
					OP_PREV: begin
						if (link_fin) begin
							fin        = 1'b1;
							res_status = ST_END;
						end else begin
							rd_en    = 1'b1;
							rd_addr  = rd_prev_q[SW-1:0];
							cursor_d = rd_prev_q;
						end
					end
					default: begin
						prev_d  = rd_prev_q;
						next_wa = rd_prev_q[SW-1:0];
						next_wd = rd_next_q;
						prev_wa = rd_next_q[SW-1:0];
						prev_wd = rd_prev_q;
						if (is_slot(rd_prev_q)) begin
							next_we = 1'b1;
						end else begin
							first_d = rd_next_q;
						end
						if (is_slot(rd_next_q)) begin
							prev_we = 1'b1;
						end else begin
							last_d = rd_prev_q;
						end
					end
				endcase
			end
			S_DATA: begin
				fin      = 1'b1;
				res_data = data_word_t'(rd_data_q);
			end
			S_APPEND: begin
				fin     = 1'b1;
				next_wa = last_q[SW-1:0];
				next_wd = alloc;
				if (out_free) begin
					if (is_slot(free_head_q)) begin
						free_head_d = rd_next_q;
					end else begin
						fresh_d = fresh_q + 1'b1;
					end
					if (is_slot(last_q)) begin
						next_we = 1'b1;
					end else begin
						first_d = alloc;
					end
					last_d  = alloc;
					count_d = count_q + 1'b1;
				end
			end
			S_REMOVE: begin
				fin      = 1'b1;
				res_data = data_word_t'(rd_data_q);
				next_wa  = cursor_q[SW-1:0];
				next_wd  = free_head_q;
				if (out_free) begin
					next_we     = 1'b1;
					free_head_d = cursor_q;
					cursor_d    = is_slot(prev_q) ? prev_q : HEAD;
					count_d     = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= TAIL;
			last_q      <= HEAD;
			cursor_q    <= HEAD;
			cur_ok_q    <= 1'b0;
			count_q     <= '0;
			free_head_q <= TAIL;
			fresh_q     <= '0;
		end else begin
			state_q     <= state_d;
			first_q     <= first_d;
			last_q      <= last_d;
			cursor_q    <= cursor_d;
			cur_ok_q    <= cur_ok_d;
			count_q     <= count_d;
			free_head_q <= free_head_d;
			fresh_q     <= fresh_d;
		end
	end

	always_ff @(posedge clk) begin
		prev_q <= prev_d;
		if (state_q == S_IDLE && req_valid) begin
			op_q  <= req_word.opcode;
			din_q <= DATA_WIDTH'(req_word.data_in);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_next_q <= next_mem[rd_addr];
			rd_prev_q <= prev_mem[rd_addr];
			rd_data_q <= data_mem[rd_addr];
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (data_we) begin
			data_mem[data_wa] <= data_wd;
		end
	end

endmodule

/* rtl/core/doubly_linked_list_cursor.sv */
// Top level of the bounded doubly linked list with a cursor.
//
// Each request word carries an opcode and an append value. Requests are
// taken one at a time: req_stall stays high from the edge that takes a word
// until its response word has been loaded into the output register.
// A word starts in S_ISSUE and, as the dependent reads of the link and
// element memories demand, goes on to S_LINK, S_DATA, S_APPEND or S_REMOVE:
// count and requests rejected at once finish in S_ISSUE; append and first
// go on to S_APPEND or S_DATA, next from the head to S_DATA, and next or
// previous that stop at an end to S_LINK; remove and next or previous that
// follow a stored link pass S_LINK, then S_REMOVE or S_DATA. A new word is
// taken on the cycle after the last response is loaded, not while busy.
// The response word sits in an output register, so the next request is
// taken while an earlier response still waits. When rsp_stall holds that
// register full, the sequencer waits on its last step and holds req_stall.
// Reset clears the list to empty, frees every slot and drops the cursor;
// the memories need no clearing pass and the block takes requests at once.
module doubly_linked_list_cursor #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  dllc_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dllc_pkg::rsp_word_t rsp_word
);
	import dllc_pkg::*;

	`include "doubly_linked_list_cursor_assert.svh"

	logic      out_free;
	logic      load;
	rsp_word_t load_word;

	dllc_engine #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.out_free (out_free),
		.load     (load),
		.load_word(load_word)
	);

	dllc_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.load_word(load_word),
		.free     (out_free),
		.valid    (rsp_valid),
		.stall    (rsp_stall),
		.word     (rsp_word)
	);

	`DLLC_ASSERT_NOW(a_load_only_busy, clk, arst_n, load, req_stall)
	`DLLC_ASSERT_NEXT(a_busy_after_take, clk, arst_n, req_valid && !req_stall, req_stall)
	`DLLC_ASSERT_NOW(a_no_overwrite, clk, arst_n, rsp_valid && rsp_stall, !load)
	`DLLC_ASSERT_NEXT(a_load_shows, clk, arst_n, load, rsp_valid && rsp_word == $past(load_word))

endmodule
